/* design/skr_pkg.sv */
// Shared types, constants and sizing helpers for the stream key replace unit.
package skr_pkg;

  localparam int KEY_LANES             = 8;
  localparam int REP_LANES             = 16;
  localparam int RES_LIMIT             = 16;
  localparam int RES_W                 = $clog2(RES_LIMIT + 1);
  localparam int QUEUE_DEPTH           = 2;
  localparam int DEF_MAX_KEY_BYTES     = 8;
  localparam int DEF_MAX_REPLACE_BYTES = 16;
  localparam int CFG_INDEX_W           = 3;
  localparam int CFG_DATA_W            = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_BYTES          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_SIZE           = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LOW    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_HIGH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd4;

  typedef struct packed {
    logic [63:0]  key_bytes;
    logic [3:0]   key_size;
    logic [127:0] replacement;
    logic [4:0]   replacement_length;
  } cfg_t;

  typedef struct packed {
    logic             stream_end;
    logic [RES_W-1:0] total;
  } plan_ctl_t;

  function automatic int win_bytes(int max_key);
    return (max_key < KEY_LANES) ? max_key : KEY_LANES;
  endfunction

  function automatic int rep_bytes(int max_rep);
    return (max_rep < REP_LANES) ? max_rep : REP_LANES;
  endfunction

endpackage

/* design/skr_queue.sv */
// Small register FIFO carrying emission plans from the front to the back.
module skr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/skr_front.sv */
// Front end: holds the match window, classifies each byte and plans its output words.
module skr_front #(
  parameter int MAX_KEY_BYTES     = skr_pkg::DEF_MAX_KEY_BYTES,
  parameter int MAX_REPLACE_BYTES = skr_pkg::DEF_MAX_REPLACE_BYTES,
  localparam int WIN              = skr_pkg::win_bytes(MAX_KEY_BYTES),
  localparam int FILL_W           = $clog2(WIN + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  skr_pkg::cfg_t       cfg,
  input  logic                key_clear,
  input  logic                push,
  input  logic [7:0]          data_byte,
  input  logic                stream_end,
  input  logic                q_full,
  output logic                q_push,
  output skr_pkg::plan_ctl_t  plan_ctl,
  output logic [FILL_W-1:0]   plan_nb,
  output logic [WIN*8-1:0]    plan_bytes
);

  localparam int REP_MAX = skr_pkg::rep_bytes(MAX_REPLACE_BYTES);
  localparam int T_W     = FILL_W + 1;
  localparam int WIDX_W  = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int RES_W   = skr_pkg::RES_W;
  localparam int SUM_W   = RES_W + 1;

  logic [7:0]              win [WIN];
  logic [FILL_W-1:0]       fill;
  logic [7:0]              wn  [WIN];
  logic [7:0]              nw  [WIN];
  logic [FILL_W-1:0]       klen;
  logic [FILL_W-1:0]       f;
  logic [FILL_W-1:0]       cnt;
  logic [FILL_W-1:0]       s;
  logic [FILL_W-1:0]       len;
  logic [FILL_W-1:0]       nb;
  logic [FILL_W-1:0]       fill_next;
  logic [WIN:0]            ok;
  logic                    is_full;
  logic [4:0]              rlen;
  logic [SUM_W-1:0]        sum;
  logic [RES_W-1:0]        total;
  logic                    accept;

  always_comb begin
    logic [3:0] k4;
    k4 = cfg.key_size;
    if (k4 == 4'd0) begin
      k4 = 4'd1;
    end
    if (k4 > 4'(WIN)) begin
      k4 = 4'(WIN);
    end
    klen = FILL_W'(k4);
    rlen = (cfg.replacement_length > 5'(REP_MAX)) ? 5'(REP_MAX) : cfg.replacement_length;
  end

  assign f   = (fill >= klen) ? '0 : fill;
  assign cnt = f + FILL_W'(1);

  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      wn[j] = (FILL_W'(j) == f) ? data_byte : win[j];
    end
  end

  // ok[n]: bytes n..cnt-1 of the extended window are a prefix of the key
  always_comb begin
    for (int sv = 0; sv <= WIN; sv++) begin
      ok[sv] = 1'b1;
      for (int i = 0; i < WIN - sv; i++) begin
        if ((sv + i < cnt) && (wn[sv + i] != cfg.key_bytes[i*8 +: 8])) begin
          ok[sv] = 1'b0;
        end
      end
    end
  end

  // smallest shift that leaves a live prefix
  always_comb begin
    s = cnt;
    for (int sv = WIN; sv >= 0; sv--) begin
      if (ok[sv] && (sv <= cnt)) begin
        s = FILL_W'(sv);
      end
    end
  end

  assign is_full   = (s == '0) && (cnt == klen);
  assign len       = cnt - s;
  assign nb        = is_full ? '0 : (stream_end ? cnt : s);
  assign fill_next = (is_full || stream_end) ? '0 : len;
  assign sum       = SUM_W'(nb) + (is_full ? SUM_W'(rlen) : '0);
  assign total     = (sum > SUM_W'(skr_pkg::RES_LIMIT)) ? RES_W'(skr_pkg::RES_LIMIT)
                                                       : sum[RES_W-1:0];

  always_comb begin
    logic [T_W-1:0] t;
    for (int j = 0; j < WIN; j++) begin
      t     = T_W'(j) + T_W'(s);
      nw[j] = wn[j];
      if (t < T_W'(WIN)) begin
        nw[j] = wn[t[WIDX_W-1:0]];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      plan_bytes[j*8 +: 8] = wn[j];
    end
  end

  assign accept              = push && !q_full;
  assign q_push              = accept && (total != '0);
  assign plan_ctl.stream_end = stream_end;
  assign plan_ctl.total      = total;
  assign plan_nb             = nb;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (key_clear) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= nw;
    end
  end

endmodule

/* design/skr_back.sv */
// Back end: plays out one planned run, one word per cycle while pop is high, and retires the plan.
module skr_back #(
  parameter int MAX_KEY_BYTES = skr_pkg::DEF_MAX_KEY_BYTES,
  localparam int WIN          = skr_pkg::win_bytes(MAX_KEY_BYTES),
  localparam int FILL_W       = $clog2(WIN + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  skr_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  skr_pkg::plan_ctl_t head_ctl,
  input  logic [FILL_W-1:0]  head_nb,
  input  logic [WIN*8-1:0]   head_bytes,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic [7:0]         out_byte,
  output logic               run_last,
  output logic               stream_done
);

  localparam int RES_W  = skr_pkg::RES_W;
  localparam int WIDX_W = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int RIDX_W = $clog2(skr_pkg::REP_LANES);

  logic [RES_W-1:0] pos;
  logic [RES_W-1:0] rep_pos;
  logic [RES_W-1:0] nb_ext;
  logic [7:0]       win_lane [WIN];
  logic [7:0]       rep_lane [skr_pkg::REP_LANES];
  logic             is_last;
  logic             fire;

  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      win_lane[j] = head_bytes[j*8 +: 8];
    end
    for (int j = 0; j < skr_pkg::REP_LANES; j++) begin
      rep_lane[j] = cfg.replacement[j*8 +: 8];
    end
  end

  assign nb_ext      = RES_W'(head_nb);
  assign rep_pos     = pos - nb_ext;
  assign is_last     = (pos == head_ctl.total - RES_W'(1));
  assign out_byte    = (pos < nb_ext) ? win_lane[pos[WIDX_W-1:0]]
                                      : rep_lane[rep_pos[RIDX_W-1:0]];
  assign run_last    = is_last;
  assign stream_done = is_last && head_ctl.stream_end;
  assign empty       = q_empty;
  assign fire        = pop && !q_empty;
  assign q_pop       = fire && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (fire) begin
      pos <= is_last ? '0 : pos + RES_W'(1);
    end
  end

endmodule

/* design/stream_key_replace_unit.sv */
// Top level of the streaming key find-and-replace unit.
//
// Bytes enter on push/full and words leave on empty/pop. A byte is classified in the
// cycle it is accepted; its run is ready once its plan heads the queue. Pass-through
// bytes sustain one byte per cycle while pop is held; a byte that releases n words
// (up to 16) gives one word per pop, and input is held off only once the two-entry
// plan queue between classifier and output sequencer is full. A byte that only
// extends a partial match without ending the stream, or whose match is deleted,
// produces no word. Writing the key or key length drops the match window's bytes.
module stream_key_replace_unit #(
  parameter int MAX_KEY_BYTES     = skr_pkg::DEF_MAX_KEY_BYTES,
  parameter int MAX_REPLACE_BYTES = skr_pkg::DEF_MAX_REPLACE_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [skr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [skr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  input  logic [7:0]                      data_byte,
  input  logic                            stream_end,
  output logic                            full,
  input  logic                            pop,
  output logic                            empty,
  output logic [7:0]                      out_byte,
  output logic                            run_last,
  output logic                            stream_done
);

  localparam int WIN     = skr_pkg::win_bytes(MAX_KEY_BYTES);
  localparam int FILL_W  = $clog2(WIN + 1);
  localparam int CTL_W   = $bits(skr_pkg::plan_ctl_t);
  localparam int BYTES_W = WIN * 8;
  localparam int ENTRY_W = CTL_W + FILL_W + BYTES_W;

  logic [63:0]        key_bytes;
  logic [3:0]         key_size;
  logic [63:0]        replacement_low;
  logic [63:0]        replacement_high;
  logic [4:0]         replacement_length;
  skr_pkg::cfg_t      cfg;
  logic               key_clear;

  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_din;
  logic [ENTRY_W-1:0] q_dout;

  skr_pkg::plan_ctl_t plan_ctl;
  logic [FILL_W-1:0]  plan_nb;
  logic [BYTES_W-1:0] plan_bytes;
  skr_pkg::plan_ctl_t head_ctl;
  logic [FILL_W-1:0]  head_nb;
  logic [BYTES_W-1:0] head_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes          <= '0;
      key_size           <= 4'd1;
      replacement_low    <= '0;
      replacement_high   <= '0;
      replacement_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        skr_pkg::REG_KEY_BYTES:          key_bytes          <= cfg_data;
        skr_pkg::REG_KEY_SIZE:           key_size           <= cfg_data[3:0];
        skr_pkg::REG_REPLACEMENT_LOW:    replacement_low    <= cfg_data;
        skr_pkg::REG_REPLACEMENT_HIGH:   replacement_high   <= cfg_data;
        skr_pkg::REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign key_clear = cfg_write && ((cfg_index == skr_pkg::REG_KEY_BYTES) ||
                                   (cfg_index == skr_pkg::REG_KEY_SIZE));

  assign cfg.key_bytes          = key_bytes;
  assign cfg.key_size           = key_size;
  assign cfg.replacement        = {replacement_high, replacement_low};
  assign cfg.replacement_length = replacement_length;

  assign full  = q_full;
  assign q_din = {plan_ctl, plan_nb, plan_bytes};

  assign head_ctl   = skr_pkg::plan_ctl_t'(q_dout[ENTRY_W-1 -: CTL_W]);
  assign head_nb    = q_dout[BYTES_W +: FILL_W];
  assign head_bytes = q_dout[BYTES_W-1:0];

  skr_front #(
    .MAX_KEY_BYTES     (MAX_KEY_BYTES),
    .MAX_REPLACE_BYTES (MAX_REPLACE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .key_clear  (key_clear),
    .push       (push),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .q_full     (q_full),
    .q_push     (q_push),
    .plan_ctl   (plan_ctl),
    .plan_nb    (plan_nb),
    .plan_bytes (plan_bytes)
  );

  skr_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (skr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  skr_back #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .head_ctl    (head_ctl),
    .head_nb     (head_nb),
    .head_bytes  (head_bytes),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .stream_done (stream_done)
  );

endmodule
